// ----- rtl/core/ssc_pkg.sv -----
// shared types and constants for the scaled system counter
package ssc_pkg;

	localparam int unsigned WIDE_W = 128;
	localparam int unsigned DIV_W = 32;
	localparam int unsigned CNT_W = 7;

	localparam logic [31:0] NANOS_PER_SEC = 32'd1000000000;
	localparam logic [62:0] TIME_MAX = 63'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] RESET_INCREMENT = 32'd16777216;

	localparam logic [1:0] CFG_FREQ = 2'd0;
	localparam logic [1:0] CFG_INCREMENT = 2'd1;
	localparam logic [1:0] CFG_ENABLE = 2'd2;

	typedef enum logic {
		OP_MUL,
		OP_DIV
	} unit_op_t;

	typedef struct packed {
		logic start;
		unit_op_t op;
		logic [WIDE_W-1:0] a;
		logic [DIV_W-1:0] b;
	} unit_req_t;

	typedef struct packed {
		logic done;
		logic [WIDE_W-1:0] result;
		logic [DIV_W-1:0] rem;
	} unit_rsp_t;

endpackage

// ----- rtl/core/ssc_if.sv -----
// channel interfaces for items, results and configuration writes
interface ssc_item_if;
	logic valid;
	logic ready;
	logic mode;
	logic [62:0] time_ns;
	logic [63:0] target_cnt;
	modport source (output valid, mode, time_ns, target_cnt, input ready);
	modport sink (input valid, mode, time_ns, target_cnt, output ready);
endinterface

interface ssc_result_if #(parameter int FRAC_W = 24);
	logic valid;
	logic ready;
	logic [63:0] count;
	logic [FRAC_W-1:0] fraction;
	logic [62:0] deadline_time;
	logic deadline_found;
	logic error;
	modport source (output valid, count, fraction, deadline_time, deadline_found, error,
		input ready);
	modport sink (input valid, count, fraction, deadline_time, deadline_found, error,
		output ready);
endinterface

interface ssc_cfg_if;
	logic valid;
	logic ready;
	logic [1:0] index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- rtl/core/ssc_serial_unit.sv -----
// bit-serial shift-add multiplier and restoring divider, 128 by 32 bits
module ssc_serial_unit (
	input logic clk,
	input logic arst_n,
	input ssc_pkg::unit_req_t req,
	output ssc_pkg::unit_rsp_t rsp
);
	import ssc_pkg::*;

	logic [WIDE_W-1:0] acc_q;
	logic [WIDE_W-1:0] mc_q;
	logic [DIV_W-1:0] mp_q;
	logic [DIV_W-1:0] rem_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;
	unit_op_t op_q;

	logic [DIV_W:0] trial;
	logic ge;

	assign trial = {rem_q, acc_q[WIDE_W-1]};
	assign ge = trial >= {1'b0, mp_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				mp_q <= req.b;
				mc_q <= req.a;
				rem_q <= '0;
				if (req.op == OP_MUL) begin
					acc_q <= '0;
					cnt_q <= CNT_W'(DIV_W - 1);
				end else begin
					acc_q <= req.a;
					cnt_q <= CNT_W'(WIDE_W - 1);
				end
			end else if (busy_q) begin
				if (op_q == OP_MUL) begin
					// one multiplier bit per cycle, multiplicand walks left
					if (mp_q[0])
						acc_q <= acc_q + mc_q;
					mc_q <= {mc_q[WIDE_W-2:0], 1'b0};
					mp_q <= {1'b0, mp_q[DIV_W-1:1]};
				end else begin
					rem_q <= ge ? DIV_W'(trial - {1'b0, mp_q}) : trial[DIV_W-1:0];
					acc_q <= {acc_q[WIDE_W-2:0], ge};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.result = acc_q;
	assign rsp.rem = rem_q;
endmodule

// ----- rtl/core/scaled_system_counter_top.sv -----
// scaled system counter: timestamp-driven fixed-point count with deadline search
//
// item channel: one transaction per access, carrying mode, time_ns and target_cnt.
// result channel: one transaction per item with count, fraction, deadline fields and
// error. cfg channel: register writes (frequency, increment, enable), always ready,
// to be issued only while no item is in flight.
// all arithmetic runs on one shared bit-serial unit, one bit per cycle. a mode 0
// item multiplies by frequency, divides by 1e9 and, while counting, multiplies by
// increment; mode 1 may add two divides, one multiply and a second advance for
// the verify pass. an item whose timestamp precedes the anchor goes straight to
// the output state with error set. a new item is taken once the previous one has
// its result in the output register; if the receiver stalls, a second finished
// result waits inside until that register frees. reset clears the count, anchor
// and remainder, sets frequency 0, increment 1.0 and enable 0.
module scaled_system_counter_top #(
	parameter int FRACTION_BITS = 24
) (
	input logic clk,
	input logic arst_n,
	ssc_item_if.sink item,
	ssc_result_if.source result,
	ssc_cfg_if.sink cfg
);
	import ssc_pkg::*;

	localparam int VW = 64 + FRACTION_BITS;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADV_MUL,
		ST_ADV_DIV,
		ST_ADV_INC,
		ST_ADV_WB,
		ST_DL_CHECK,
		ST_DL_DIV1,
		ST_DL_MUL,
		ST_DL_DIV2,
		ST_DL_CMP,
		ST_OUTPUT
	} state_t;

	state_t state_q;
	unit_req_t req_q;
	unit_rsp_t rsp;

	logic [31:0] freq_q;
	logic [31:0] inc_q;
	logic enable_q;

	logic [63:0] int_q;
	logic [FRACTION_BITS-1:0] frac_q;
	logic [62:0] anchor_q;
	logic [29:0] trem_q;

	logic mode_q;
	logic [62:0] t_q;
	logic [63:0] target_q;
	logic [62:0] adv_t_q;
	logic verify_q;
	logic [29:0] new_rem_q;
	logic [VW-1:0] value_q;
	logic [WIDE_W-1:0] elapsed_q;

	logic [63:0] res_count_q;
	logic [FRACTION_BITS-1:0] res_frac_q;
	logic [62:0] res_dl_q;
	logic res_found_q;
	logic res_err_q;

	logic out_valid_q;
	logic [63:0] out_count_q;
	logic [FRACTION_BITS-1:0] out_frac_q;
	logic [62:0] out_dl_q;
	logic out_found_q;
	logic out_err_q;

	logic counting;
	logic [63:0] delta;
	logic [63:0] remaining;
	logic [63:0] value_int;

	ssc_serial_unit u_unit (
		.clk (clk),
		.arst_n (arst_n),
		.req (req_q),
		.rsp (rsp)
	);

	assign counting = enable_q && (inc_q != '0);
	assign delta = target_q - int_q;
	assign value_int = value_q[VW-1:FRACTION_BITS];
	assign remaining = target_q - value_int;

	assign cfg.ready = 1'b1;
	assign item.ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= '0;
			inc_q <= RESET_INCREMENT;
			enable_q <= 1'b0;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FREQ: freq_q <= cfg.data;
				CFG_INCREMENT: inc_q <= cfg.data;
				CFG_ENABLE: enable_q <= cfg.data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			req_q <= '0;
			int_q <= '0;
			frac_q <= '0;
			anchor_q <= '0;
			trem_q <= '0;
			verify_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (result.valid && result.ready && state_q != ST_OUTPUT)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (item.valid) begin
						mode_q <= item.mode;
						t_q <= item.time_ns;
						target_q <= item.target_cnt;
						res_count_q <= '0;
						res_frac_q <= '0;
						res_dl_q <= '0;
						res_found_q <= 1'b0;
						if (item.time_ns < anchor_q) begin
							res_err_q <= 1'b1;
							state_q <= ST_OUTPUT;
						end else begin
							res_err_q <= 1'b0;
							adv_t_q <= item.time_ns;
							verify_q <= 1'b0;
							req_q <= '{start: 1'b1, op: OP_MUL,
								a: WIDE_W'(item.time_ns - anchor_q), b: freq_q};
							state_q <= ST_ADV_MUL;
						end
					end
				end
				ST_ADV_MUL: begin
					if (rsp.done) begin
						req_q <= '{start: 1'b1, op: OP_DIV,
							a: rsp.result + WIDE_W'(trem_q), b: NANOS_PER_SEC};
						state_q <= ST_ADV_DIV;
					end else begin
						req_q.start <= 1'b0;
					end
				end
				ST_ADV_DIV: begin
					if (rsp.done) begin
						new_rem_q <= rsp.rem[29:0];
						if (counting) begin
							req_q <= '{start: 1'b1, op: OP_MUL, a: rsp.result, b: inc_q};
							state_q <= ST_ADV_INC;
						end else begin
							value_q <= {int_q, frac_q};
							state_q <= ST_ADV_WB;
						end
					end else begin
						req_q.start <= 1'b0;
					end
				end
				ST_ADV_INC: begin
					if (rsp.done) begin
						value_q <= {int_q, frac_q} + rsp.result[VW-1:0];
						state_q <= ST_ADV_WB;
					end else begin
						req_q.start <= 1'b0;
					end
				end
				ST_ADV_WB: begin
					if (!verify_q) begin
						int_q <= value_int;
						frac_q <= value_q[FRACTION_BITS-1:0];
						anchor_q <= adv_t_q;
						trem_q <= new_rem_q;
						res_count_q <= value_int;
						res_frac_q <= value_q[FRACTION_BITS-1:0];
						state_q <= mode_q ? ST_DL_CHECK : ST_OUTPUT;
					end else begin
						// verify pass: count at the candidate must have reached the target
						if (remaining == '0 || remaining[63]) begin
							res_found_q <= 1'b1;
							res_dl_q <= adv_t_q;
						end
						state_q <= ST_OUTPUT;
					end
				end
				ST_DL_CHECK: begin
					if (!counting) begin
						state_q <= ST_OUTPUT;
					end else if (delta == '0 || delta[63]) begin
						res_found_q <= 1'b1;
						res_dl_q <= t_q;
						state_q <= ST_OUTPUT;
					end else if (freq_q == '0) begin
						state_q <= ST_OUTPUT;
					end else begin
						req_q <= '{start: 1'b1, op: OP_DIV,
							a: (WIDE_W'(delta) << FRACTION_BITS) - WIDE_W'(frac_q), b: inc_q};
						state_q <= ST_DL_DIV1;
					end
				end
				ST_DL_DIV1: begin
					if (rsp.done) begin
						// ceiling of ticks needed
						req_q <= '{start: 1'b1, op: OP_MUL,
							a: rsp.result + WIDE_W'(rsp.rem != '0), b: NANOS_PER_SEC};
						state_q <= ST_DL_MUL;
					end else begin
						req_q.start <= 1'b0;
					end
				end
				ST_DL_MUL: begin
					if (rsp.done) begin
						req_q <= '{start: 1'b1, op: OP_DIV,
							a: rsp.result - WIDE_W'(trem_q), b: freq_q};
						state_q <= ST_DL_DIV2;
					end else begin
						req_q.start <= 1'b0;
					end
				end
				ST_DL_DIV2: begin
					if (rsp.done) begin
						elapsed_q <= rsp.result + WIDE_W'(rsp.rem != '0);
						state_q <= ST_DL_CMP;
					end else begin
						req_q.start <= 1'b0;
					end
				end
				ST_DL_CMP: begin
					if (elapsed_q > WIDE_W'(TIME_MAX - t_q)) begin
						state_q <= ST_OUTPUT;
					end else begin
						// anchor now equals t_q, so elapsed time is the offset itself
						adv_t_q <= t_q + elapsed_q[62:0];
						verify_q <= 1'b1;
						req_q <= '{start: 1'b1, op: OP_MUL,
							a: WIDE_W'(elapsed_q[62:0]), b: freq_q};
						state_q <= ST_ADV_MUL;
					end
				end
				ST_OUTPUT: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_count_q <= res_count_q;
						out_frac_q <= res_frac_q;
						out_dl_q <= res_dl_q;
						out_found_q <= res_found_q;
						out_err_q <= res_err_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid = out_valid_q;
	assign result.count = out_count_q;
	assign result.fraction = out_frac_q;
	assign result.deadline_time = out_dl_q;
	assign result.deadline_found = out_found_q;
	assign result.error = out_err_q;

	a_unit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q != ST_IDLE)
		else $error("arithmetic unit finished with no item in flight");

	a_err_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.error |-> !result.deadline_found && result.count == '0)
		else $error("error result carries count or deadline");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> !item.ready)
		else $error("second item taken while one is in flight");
endmodule

// ----- test/testbench.sv -----
// testbench for the scaled system counter: random and directed timestamps checked against a predictor
`timescale 1ns / 100ps

module testbench;
	import ssc_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 3000000;
	localparam logic [127:0] MASK88 = (128'd1 << 88) - 128'd1;

	typedef struct {
		logic [63:0] ci;
		logic [23:0] cf;
		logic [62:0] at;
		logic [29:0] rem;
	} ctr_t;

	typedef struct {
		logic mode;
		logic late;        // timestamp below the anchor
		logic absolute;    // dt is the full timestamp
		logic [62:0] dt;
		logic near;        // target relative to the current count
		logic [63:0] target;
	} stim_t;

	typedef struct {
		logic [63:0] count;
		logic [23:0] fraction;
		logic [62:0] deadline_time;
		logic deadline_found;
		logic error;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ssc_item_if item();
	ssc_result_if #(.FRAC_W(24)) result();
	ssc_cfg_if cfg();

	scaled_system_counter_top #(.FRACTION_BITS(24)) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source),
		.cfg(cfg.sink)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	ctr_t counter_m;
	logic [31:0] freq_m;
	logic [31:0] inc_m;
	logic en_m;

	stim_t pending_items[$];
	outcome_t expected_outcomes[$];
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned fail_count;
	int unsigned cycles;
	bit hold_go, hold_seen;
	int unsigned hold_left;

	function automatic ctr_t advance_to(ctr_t s, logic [62:0] t);
		logic [127:0] num, ticks, val, prod;
		num = 128'(t - s.at) * 128'(freq_m) + 128'(s.rem);
		ticks = num / 128'(NANOS_PER_SEC);
		s.rem = 30'(num % 128'(NANOS_PER_SEC));
		val = {40'd0, s.ci, s.cf};
		if (en_m && inc_m != 0) begin
			prod = (ticks * 128'(inc_m)) & MASK88;
			val = (val + prod) & MASK88;
		end
		s.ci = val[87:24];
		s.cf = val[23:0];
		s.at = t;
		return s;
	endfunction

	function automatic logic find_deadline(ctr_t c, logic [63:0] target, logic [62:0] from,
			output logic [62:0] dl);
		logic [63:0] delta, left;
		logic [127:0] need, ticks, tnum, el;
		ctr_t cand;
		dl = '0;
		if (!en_m || inc_m == 0) return 1'b0;
		delta = target - c.ci;
		if (delta == 0 || delta > 64'(TIME_MAX)) begin
			dl = from;
			return 1'b1;
		end
		if (freq_m == 0) return 1'b0;
		need = (128'(delta) << 24) - 128'(c.cf);
		ticks = need / 128'(inc_m);
		if (need % 128'(inc_m) != 0) ticks = ticks + 1;
		tnum = ticks * 128'(NANOS_PER_SEC) - 128'(c.rem);
		el = tnum / 128'(freq_m);
		if (tnum % 128'(freq_m) != 0) el = el + 1;
		if (el > 128'(TIME_MAX - from)) return 1'b0;
		cand = advance_to(c, from + el[62:0]);
		left = target - cand.ci;
		if (left != 0 && left <= 64'(TIME_MAX)) return 1'b0;
		dl = from + el[62:0];
		return 1'b1;
	endfunction

	// updates the counter state and returns what the block should answer
	function automatic outcome_t predict_access(logic mode, logic [62:0] t, logic [63:0] target);
		outcome_t o;
		logic [62:0] dl;
		logic found;
		o = '{default: '0};
		if (t < counter_m.at) begin
			o.error = 1'b1;
			return o;
		end
		counter_m = advance_to(counter_m, t);
		if (mode) begin
			found = find_deadline(counter_m, target, t, dl);
			o.deadline_found = found;
			o.deadline_time = found ? dl : '0;
		end
		o.count = counter_m.ci;
		o.fraction = counter_m.cf;
		return o;
	endfunction

	task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %h expected %h", field, got, want);
		fail_count++;
	endtask

	// driver: presents pending items, predicts each accepted transaction
	always @(posedge clk or negedge arst_n) begin
		stim_t s;
		logic [62:0] t;
		if (!arst_n) begin
			item.valid <= 1'b0;
			item.mode <= 1'b0;
			item.time_ns <= '0;
			item.target_cnt <= '0;
		end else begin
			if (item.valid && item.ready)
				expected_outcomes.push_back(predict_access(item.mode, item.time_ns,
					item.target_cnt));
			if (!item.valid || item.ready) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					s = pending_items.pop_front();
					if (s.late && counter_m.at != 0)
						t = s.dt % counter_m.at;
					else if (s.absolute)
						t = s.dt;
					else if (s.dt > TIME_MAX - counter_m.at)
						t = TIME_MAX;
					else
						t = counter_m.at + s.dt;
					item.valid <= 1'b1;
					item.mode <= s.mode;
					item.time_ns <= t;
					item.target_cnt <= s.near ? counter_m.ci + s.target : s.target;
				end else begin
					item.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_go != hold_seen) begin
			hold_seen <= hold_go;
			hold_left <= 3000;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
		end
	end

	// monitor: checks each result transaction against the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		outcome_t w;
		if (!arst_n) begin
			result.ready <= 1'b0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_outcomes.size() == 0) begin
					$display("unexpected result transaction");
					fail_count++;
				end else begin
					w = expected_outcomes.pop_front();
					if (result.count !== w.count)
						report_mismatch("count", result.count, w.count);
					if (result.fraction !== w.fraction)
						report_mismatch("fraction", 64'(result.fraction), 64'(w.fraction));
					if (result.deadline_time !== w.deadline_time)
						report_mismatch("deadline_time", 64'(result.deadline_time),
							64'(w.deadline_time));
					if (result.deadline_found !== w.deadline_found)
						report_mismatch("deadline_found", 64'(result.deadline_found),
							64'(w.deadline_found));
					if (result.error !== w.error)
						report_mismatch("error", 64'(result.error), 64'(w.error));
				end
			end
			result.ready <= (hold_left == 0 && hold_go == hold_seen &&
				$urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		@(posedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= index;
		cfg.data <= data;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		case (index)
			CFG_FREQ: freq_m = data;
			CFG_INCREMENT: inc_m = data;
			CFG_ENABLE: en_m = data[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_items.size() > 0 || item.valid || expected_outcomes.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic setup(logic [31:0] f, logic [31:0] inc, logic en);
		drain();
		write_reg(CFG_FREQ, f);
		write_reg(CFG_INCREMENT, inc);
		write_reg(CFG_ENABLE, {31'd0, en});
	endtask

	task automatic add_item(logic mode, logic [62:0] dt, logic near, logic [63:0] target);
		pending_items.push_back('{mode, 1'b0, 1'b0, dt, near, target});
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic add_random_item();
		stim_t s;
		int unsigned r;
		s = '{default: '0};
		s.mode = 1'($urandom_range(1));
		r = $urandom_range(99);
		if (r < 5) s.late = 1'b1;
		if (r < 5) s.dt = 63'(rand64());
		else if (r < 15) s.dt = '0;
		else if (r < 60) s.dt = 63'($urandom_range(2000));
		else if (r < 90) s.dt = 63'($urandom_range(2000000000));
		else s.dt = 63'(rand64()) >> $urandom_range(62, 22);
		r = $urandom_range(99);
		s.near = (r < 80);
		if (r < 50) s.target = 64'($urandom_range(3000)) - 64'd500;
		else if (r < 80) s.target = rand64() >> $urandom_range(63, 10);
		else s.target = rand64();
		pending_items.push_back(s);
	endtask

	initial begin
		int unsigned ph;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		hold_go = 1'b0;
		counter_m = '{default: '0};
		freq_m = 32'd0;
		inc_m = RESET_INCREMENT;
		en_m = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// disabled after reset
		add_item(1'b0, 63'd100, 1'b0, 64'd0);
		add_item(1'b1, 63'd50, 1'b1, 64'd10);
		add_item(1'b1, 63'd0, 1'b0, '1);

		setup(32'd1000000000, RESET_INCREMENT, 1'b1);
		add_item(1'b0, 63'd1000, 1'b0, 64'd0);
		add_item(1'b1, 63'd7, 1'b1, 64'd0);          // target equals count before the advance
		add_item(1'b1, 63'd7, 1'b1, 64'hFFFF_FFFF_FFFF_FF00); // target passed
		add_item(1'b1, 63'd3, 1'b1, 64'd1234);
		add_item(1'b1, 63'd0, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF);
		pending_items.push_back('{1'b0, 1'b1, 1'b0, 63'd5, 1'b0, 64'd0}); // late timestamp

		setup(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
		add_item(1'b0, 63'd12345, 1'b0, 64'd0);
		add_item(1'b1, 63'd1, 1'b1, 64'd99999);
		add_item(1'b1, 63'd2000000000, 1'b0, '1);

		setup(32'd0, RESET_INCREMENT, 1'b1);       // zero frequency
		add_item(1'b1, 63'd10, 1'b1, 64'd5);
		add_item(1'b1, 63'd10, 1'b1, 64'd0);

		setup(32'd1000, 32'd0, 1'b1);              // zero increment
		add_item(1'b1, 63'd10, 1'b1, 64'd5);

		setup(32'd1, 32'd1, 1'b1);                 // deadline far beyond the time range
		add_item(1'b1, 63'd10, 1'b1, 64'h7000_0000_0000_0000);
		add_item(1'b1, 63'd10, 1'b1, 64'd3);

		for (ph = 0; ph < 8; ph++) begin
			case ($urandom_range(3))
				0: setup($urandom, $urandom, 1'b1);
				1: setup($urandom_range(100000000, 1), $urandom_range(50000000, 1), 1'b1);
				2: setup(32'hFFFF_FFFF, $urandom_range(1), 1'($urandom_range(1)));
				default: setup($urandom_range(3), 32'hFFFF_FFFF, 1'b1);
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 72; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 72; end
				default: begin send_idle_pct = 20; recv_stall_pct = 20; end
			endcase
			if (ph == 2) hold_go = ~hold_go;     // long receiver hold-off
			repeat (100) add_random_item();
			if (ph == 5) begin
				drain();                         // sender waits for every result
				repeat (50) add_random_item();
			end
		end

		// far end of the time range, random items, then arbitrary late timestamps
		send_idle_pct = 0;
		recv_stall_pct = 20;
		setup($urandom, $urandom, 1'b1);
		add_item(1'b1, 63'h6000_0000_0000_0000, 1'b1, 64'd100);
		repeat (20) add_random_item();
		repeat (15) pending_items.push_back('{1'b1, 1'b1, 1'b0, 63'(rand64()), 1'b0, rand64()});
		pending_items.push_back('{1'b1, 1'b0, 1'b1, TIME_MAX, 1'b0, '1});
		add_item(1'b0, 63'd0, 1'b0, 64'd0);
		drain();
		repeat (50) @(posedge clk);
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
